// ----- rtl/grh_pkg.sv -----
// Shared constants, types and the cotangent table function for the horizontal-hit ray caster.
package grh_pkg;

	localparam int MAP_SIDE = 64;
	localparam int TEXTURE_SIZE = 64;
	localparam int COT_TABLE_DEPTH = 1024;

	localparam logic [31:0] COT_MAX = 32'h7FFF_FFFF;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST = 1'b1;

	localparam logic ADDR_WIDTH_REG = 1'b0;
	localparam logic ADDR_HEIGHT_REG = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PREP,
		ST_START,
		ST_CHECK,
		ST_READ,
		ST_TEST,
		ST_DX,
		ST_SQ,
		ST_SUM,
		ST_ROOT,
		ST_OUT
	} state_t;

	// Cotangent of pi*i/depth in Q16.16, from Q2.30 series; evaluated at elaboration only.
	function automatic logic signed [31:0] cot_entry(input int unsigned i, input int unsigned d);
		logic [63:0] j;
		logic neg;
		logic [63:0] th;
		logic [63:0] x2;
		logic [63:0] st;
		logic [63:0] ct;
		logic [63:0] q;
		logic signed [63:0] s;
		logic signed [63:0] c;
		if (i == 0 || i >= d) begin
			return COT_MAX;
		end
		if (2 * i <= d) begin
			j = 64'(i);
			neg = 1'b0;
		end else begin
			j = 64'(d - i);
			neg = 1'b1;
		end
		th = (PI_Q30 * j) / 64'(d);
		x2 = (th * th) >> 30;
		st = th;
		s = $signed(th);
		ct = 64'd1 << 30;
		c = $signed(ct);
		for (int n = 1; n <= 8; n++) begin
			st = ((st * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			ct = ((ct * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				s = s - $signed(st);
				c = c - $signed(ct);
			end else begin
				s = s + $signed(st);
				c = c + $signed(ct);
			end
		end
		if (c < 0) begin
			c = 0;
		end
		if (s <= 0) begin
			return neg ? -$signed(COT_MAX) : $signed(COT_MAX);
		end
		q = (64'(c) << 16) / 64'(s);
		if (q > 64'(COT_MAX)) begin
			q = 64'(COT_MAX);
		end
		return neg ? -$signed(q[31:0]) : $signed(q[31:0]);
	endfunction

endpackage

// ----- rtl/grid_ray_horizontal_hit.sv -----
// Top level of the horizontal grid-line ray caster with its wall map.
// Usage:
// Input words (opcode, cell fields, camera, angle, vertical distance) arrive on a
// valid/ready channel; each word yields exactly one result word on the output
// valid/ready channel. A write word stores one wall bit and returns all zeros.
// A cast word marches from horizontal grid line to grid line, one map read per
// row, then takes an integer square root of the squared distance.
// A write word passes through PREP and OUT; a cast word passes through PREP, START,
// the CHECK/READ/TEST march loop (one map read per row, at most MAP_SIDE - 1 rows),
// then DX, SQ, SUM, the bit-pair square root in ROOT, and OUT.
// One word is in work at a time; in_ready rises again once the result has been
// loaded into the output register, so the next word may enter while a result
// still waits for out_ready. The output register holds its word while stalled.
// After reset the block clears the whole wall map, one cell a cycle; no word is
// accepted during that pass. Configuration writes over the APB port are taken at
// any time, and map_width and map_height reset to 64.
module grid_ray_horizontal_hit #(
	parameter int MAP_SIDE = grh_pkg::MAP_SIDE,
	parameter int TEXTURE_SIZE = grh_pkg::TEXTURE_SIZE,
	parameter int COT_TABLE_DEPTH = grh_pkg::COT_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [5:0]         cell_col,
	input  logic [5:0]         cell_row,
	input  logic               cell_wall,
	input  logic [21:0]        cam_x,
	input  logic [21:0]        cam_y,
	input  logic [15:0]        angle,
	input  logic [31:0]        vertical_distance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] hit_x,
	output logic [6:0]         hit_row,
	output logic [31:0]        hit_distance,
	output logic [7:0]         texture_column,
	output logic               facing_down,
	output logic               closer_than_vertical
);

	localparam int DEPTH = MAP_SIDE * MAP_SIDE;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(MAP_SIDE);
	localparam int CW = $clog2(COT_TABLE_DEPTH);
	localparam int RW = (SW > 6 ? SW : 6) + 2;

	// Constant cotangent table, built at elaboration.
	logic signed [31:0] cot_rom [COT_TABLE_DEPTH];
	for (genvar g = 0; g < COT_TABLE_DEPTH; g++) begin : g_cot
		assign cot_rom[g] = grh_pkg::cot_entry(g, COT_TABLE_DEPTH);
	end

	grh_pkg::state_t state_q, state_d;

	logic [6:0] width_q, height_q;
	logic [AW:0] clr_cnt_q;
	logic [AW-1:0] clr_addr;

	logic [21:0] cx_q, cy_q;
	logic [15:0] ang_q;
	logic [31:0] vd_q;
	logic signed [31:0] cot_q;
	logic down_q;
	logic signed [47:0] prod_q;
	logic signed [39:0] x_q;
	logic signed [RW-1:0] row_q;
	logic [SW-1:0] wcol_q, wrow_q;
	logic wwall_q;
	logic wok_q;
	logic signed [40:0] dx_q;
	logic signed [RW+16:0] dy_q;
	logic [63:0] dx2_q, dy2_q;
	logic [63:0] rem_q, res_q;
	logic [5:0] it_q;
	logic dsat_q;
	logic is_write_q;
	logic started_q;

	// RAM interface.
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic ram_wdata, ram_rdata;

	grh_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign clr_addr = clr_cnt_q[AW-1:0];

	// APB.
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		case (paddr[2])
			grh_pkg::ADDR_WIDTH_REG: prdata = {25'd0, width_q};
			grh_pkg::ADDR_HEIGHT_REG: prdata = {25'd0, height_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 7'd64;
			height_q <= 7'd64;
		end else if (cfg_wr) begin
			case (paddr[2])
				grh_pkg::ADDR_WIDTH_REG: width_q <= pwdata[6:0];
				grh_pkg::ADDR_HEIGHT_REG: height_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Effective bounds.
	logic [8:0] w_eff, h_eff;
	assign w_eff = (32'(width_q) < MAP_SIDE) ? 9'(width_q) : 9'(MAP_SIDE);
	assign h_eff = (32'(height_q) < MAP_SIDE) ? 9'(height_q) : 9'(MAP_SIDE);

	logic in_fire, out_fire;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (state_q == grh_pkg::ST_IDLE);

	// Bounds check on the current march point.
	logic in_bounds;
	logic signed [40:0] wlim;
	assign wlim = $signed({16'd0, w_eff, 16'd0});
	assign in_bounds = (x_q >= 0) && (41'(x_q) < wlim) && (row_q > 0)
		&& (row_q < $signed(RW'({1'b0, h_eff})));

	logic [RW-1:0] rd_row;
	assign rd_row = down_q ? row_q : row_q - RW'(1);

	assign ram_raddr = AW'(rd_row[SW-1:0]) * AW'(MAP_SIDE) + AW'(x_q[16+SW-1:16]);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = AW'(32'(wrow_q) * MAP_SIDE + 32'(wcol_q));
		ram_wdata = wwall_q;
		if (state_q == grh_pkg::ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_addr;
			ram_wdata = 1'b0;
		end else if (state_q == grh_pkg::ST_PREP && is_write_q && wok_q) begin
			ram_we = 1'b1;
		end
	end

	// Square root step.
	logic [63:0] bit_v, trial;
	logic [6:0] sh;
	assign sh = 7'd62 - {it_q, 1'b0};
	assign bit_v = 64'd1 << sh;
	assign trial = res_q + bit_v;

	logic done_root;
	assign done_root = (it_q == 6'd31);

	always_comb begin
		state_d = state_q;
		case (state_q)
			grh_pkg::ST_CLEAR: if (clr_cnt_q == (AW+1)'(DEPTH - 1)) state_d = grh_pkg::ST_IDLE;
			grh_pkg::ST_IDLE: if (in_fire) state_d = grh_pkg::ST_PREP;
			grh_pkg::ST_PREP: state_d = is_write_q ? grh_pkg::ST_OUT : grh_pkg::ST_START;
			grh_pkg::ST_START: state_d = grh_pkg::ST_CHECK;
			grh_pkg::ST_CHECK: if (started_q)
				state_d = in_bounds ? grh_pkg::ST_READ : grh_pkg::ST_DX;
			grh_pkg::ST_READ: state_d = grh_pkg::ST_TEST;
			grh_pkg::ST_TEST: state_d = ram_rdata ? grh_pkg::ST_DX : grh_pkg::ST_CHECK;
			grh_pkg::ST_DX: state_d = grh_pkg::ST_SQ;
			grh_pkg::ST_SQ: state_d = grh_pkg::ST_SUM;
			grh_pkg::ST_SUM: state_d = grh_pkg::ST_ROOT;
			grh_pkg::ST_ROOT: if (done_root) state_d = grh_pkg::ST_OUT;
			grh_pkg::ST_OUT: if (!out_valid || out_ready) state_d = grh_pkg::ST_IDLE;
			default: state_d = grh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grh_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == grh_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	logic [CW-1:0] cidx;
	assign cidx = CW'((32'(ang_q[14:0]) * COT_TABLE_DEPTH) >> 15);

	logic [15:0] fy;
	assign fy = cy_q[15:0];
	logic [16:0] dyd;
	assign dyd = (fy != 16'd0) ? (17'h10000 - 17'(fy)) : 17'd0;

	logic signed [39:0] fl;
	assign fl = 40'(prod_q >>> 16);

	logic [31:0] adx;
	assign adx = dx_q[40] ? 32'(-dx_q) : 32'(dx_q);
	logic [RW+15:0] ady;
	assign ady = dy_q[RW+16] ? (RW+16)'(-dy_q) : (RW+16)'(dy_q);
	logic adx_big;
	assign adx_big = dx_q[40] ? ((-dx_q) >= 41'sh1_0000_0000) : (dx_q >= 41'sh1_0000_0000);

	always_ff @(posedge clk) begin
		case (state_q)
			grh_pkg::ST_IDLE: if (in_fire) begin
				is_write_q <= (opcode == grh_pkg::OP_WRITE);
				cx_q <= cam_x;
				cy_q <= cam_y;
				ang_q <= angle;
				vd_q <= vertical_distance;
				wcol_q <= SW'(cell_col);
				wrow_q <= SW'(cell_row);
				wwall_q <= cell_wall;
				wok_q <= (32'(cell_col) < MAP_SIDE) && (32'(cell_row) < MAP_SIDE);
			end
			grh_pkg::ST_PREP: begin
				cot_q <= cot_rom[cidx];
				down_q <= ang_q[15];
			end
			grh_pkg::ST_START: begin
				if (!down_q) begin
					prod_q <= $signed({32'd0, fy}) * 48'(cot_q);
				end else begin
					prod_q <= $signed({31'd0, dyd}) * 48'(cot_q);
				end
			end
			default: ;
		endcase
	end

	// March registers.
	always_ff @(posedge clk) begin
		if (state_q == grh_pkg::ST_START) begin
			started_q <= 1'b0;
			row_q <= down_q ? RW'(cy_q[21:16]) + RW'(fy != 16'd0) : RW'(cy_q[21:16]);
		end else if (state_q == grh_pkg::ST_CHECK && !started_q) begin
			started_q <= 1'b1;
		end
		if (state_q == grh_pkg::ST_CHECK && !started_q) begin
			x_q <= 40'(cx_q) + (down_q ? -fl : fl);
		end else if (state_q == grh_pkg::ST_TEST && !ram_rdata) begin
			x_q <= down_q ? x_q - 40'(cot_q) : x_q + 40'(cot_q);
			row_q <= down_q ? row_q + RW'(1) : row_q - RW'(1);
		end
		if (state_q == grh_pkg::ST_DX) begin
			dx_q <= 41'(x_q) - 41'(cx_q);
			dy_q <= $signed({row_q, 16'd0}) - $signed((RW+17)'(cy_q));
		end
		if (state_q == grh_pkg::ST_SQ) begin
			dx2_q <= 64'(adx) * 64'(adx);
			dy2_q <= 64'(ady) * 64'(ady);
			dsat_q <= adx_big;
		end
		if (state_q == grh_pkg::ST_SUM) begin
			rem_q <= dx2_q + dy2_q;
			dsat_q <= dsat_q || ((dx2_q + dy2_q) < dx2_q);
			res_q <= '0;
			it_q <= '0;
		end
		if (state_q == grh_pkg::ST_ROOT) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_v;
			end else begin
				res_q <= res_q >> 1;
			end
			it_q <= it_q + 6'd1;
		end
	end

	// The CHECK state with started_q low only forms the start point.
	// Output register.
	logic [31:0] dist_v;
	assign dist_v = dsat_q ? 32'hFFFF_FFFF : res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == grh_pkg::ST_OUT && (!out_valid || out_ready)) begin
			out_valid <= 1'b1;
		end else if (out_fire) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == grh_pkg::ST_OUT && (!out_valid || out_ready)) begin
			if (is_write_q) begin
				hit_x <= '0;
				hit_row <= '0;
				hit_distance <= '0;
				texture_column <= '0;
				facing_down <= 1'b0;
				closer_than_vertical <= 1'b0;
			end else begin
				hit_x <= (x_q > 40'sh7FFF_FFFF) ? 32'h7FFF_FFFF
					: (x_q < -40'sh8000_0000) ? 32'h8000_0000 : x_q[31:0];
				hit_row <= 7'(row_q);
				hit_distance <= dist_v;
				texture_column <= 8'((32'(x_q[15:0]) * TEXTURE_SIZE) >> 16);
				facing_down <= down_q;
				closer_than_vertical <= dist_v < vd_q;
			end
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == grh_pkg::ST_IDLE) else $error("ready outside idle");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == grh_pkg::ST_CLEAR |-> !in_ready) else $error("accept during clear");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_distance))
		else $error("output changed under stall");

endmodule

// ----- rtl/grh_ram.sv -----
// Generic single-port-write, single-read synchronous RAM with registered read data.
module grh_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
